### rtl/cubic_bezier_flattener_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the cubic Bezier flattener.
// ----------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_FLATTENER_MACROS_SVH
`define CUBIC_BEZIER_FLATTENER_MACROS_SVH

`ifndef SYNTHESIS
`define CBF_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define CBF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define CBF_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define CBF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/cbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_pkg
// Constants shared by the cubic Bezier flattener modules.
// ----------------------------------------------------------------------------
package cbf_pkg;
    localparam int CBF_MAX_DEPTH   = 6;
    localparam int CBF_COORD_WIDTH = 24;
    localparam int CBF_TOL_W       = 52;
    localparam logic [CBF_TOL_W-1:0] CBF_TOL_RESET = CBF_TOL_W'(65536);
    localparam int CBF_PDATA_W     = 64;
    localparam int CBF_PADDR_W     = 4;
    localparam int CBF_REG_STRIDE_LSB = 3;
    localparam logic [CBF_PADDR_W-CBF_REG_STRIDE_LSB-1:0] CBF_REG_FLAT_TOL = '0;
endpackage

### rtl/cbf_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf channel interfaces
// Curve input channel and segment output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cbf_curve_if #(parameter int COORD_WIDTH = cbf_pkg::CBF_COORD_WIDTH) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] p0_x;
    logic signed [COORD_WIDTH-1:0] p0_y;
    logic signed [COORD_WIDTH-1:0] c1_x;
    logic signed [COORD_WIDTH-1:0] c1_y;
    logic signed [COORD_WIDTH-1:0] c2_x;
    logic signed [COORD_WIDTH-1:0] c2_y;
    logic signed [COORD_WIDTH-1:0] p3_x;
    logic signed [COORD_WIDTH-1:0] p3_y;

    modport source (output valid, p0_x, p0_y, c1_x, c1_y, c2_x, c2_y, p3_x, p3_y,
                    input ready);
    modport sink (input valid, p0_x, p0_y, c1_x, c1_y, c2_x, c2_y, p3_x, p3_y,
                  output ready);
endinterface

interface cbf_seg_if #(parameter int COORD_WIDTH = cbf_pkg::CBF_COORD_WIDTH) ();
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] seg_start_x;
    logic signed [COORD_WIDTH-1:0] seg_start_y;
    logic signed [COORD_WIDTH-1:0] seg_end_x;
    logic signed [COORD_WIDTH-1:0] seg_end_y;
    logic                          last_segment;

    modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                    last_segment, input ready);
    modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  last_segment, output ready);
endinterface

### rtl/cbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_front
// Accepts curves and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module cbf_front #(
    parameter int COORD_WIDTH = cbf_pkg::CBF_COORD_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cbf_curve_if.sink   i_curve,
    cbf_curve_if.source o_curve
);
    localparam int IW = 8 * COORD_WIDTH;

    logic [IW-1:0] r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_cnt;
    logic          w_push;
    logic          w_pop;
    logic [IW-1:0] w_din;
    logic [IW-1:0] w_dout;

    assign i_curve.ready = (r_cnt != 2'd2);
    assign o_curve.valid = (r_cnt != 2'd0);
    assign w_push = i_curve.valid && i_curve.ready;
    assign w_pop  = o_curve.valid && o_curve.ready;
    assign w_din  = {i_curve.p0_x, i_curve.p0_y, i_curve.c1_x, i_curve.c1_y,
                     i_curve.c2_x, i_curve.c2_y, i_curve.p3_x, i_curve.p3_y};
    assign w_dout = r_mem[r_rd];
    assign {o_curve.p0_x, o_curve.p0_y, o_curve.c1_x, o_curve.c1_y,
            o_curve.c2_x, o_curve.c2_y, o_curve.p3_x, o_curve.p3_y} = w_dout;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_din;
        end
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end
endmodule

### rtl/cbf_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbf_engine
// Depth-first de Casteljau subdivision with an explicit stack; emits segments.
// ----------------------------------------------------------------------------
`include "cubic_bezier_flattener_macros.svh"
module cbf_engine #(
    parameter int MAX_DEPTH   = cbf_pkg::CBF_MAX_DEPTH,
    parameter int COORD_WIDTH = cbf_pkg::CBF_COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [cbf_pkg::CBF_TOL_W-1:0] i_tol,
    cbf_curve_if.sink                     i_curve,
    cbf_seg_if.source                     o_seg
);
    import cbf_pkg::*;

    localparam int CW   = COORD_WIDTH;
    localparam int TW   = COORD_WIDTH + 3;
    localparam int LW   = $clog2(MAX_DEPTH + 1);
    localparam int IDXW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef enum logic [2:0] {S_IDLE, S_TERMS, S_SQUARE, S_DECIDE, S_EMIT} t_state;

    t_state               r_state;
    logic signed [CW-1:0] r_pt  [4][2];
    logic signed [CW-1:0] r_stk [MAX_DEPTH][4][2];
    logic [LW-1:0]        r_lvl [MAX_DEPTH];
    logic [LW-1:0]        r_sp;
    logic [LW-1:0]        r_level;
    logic [31:0]          r_mag [4];
    logic                 r_sat [4];
    logic [63:0]          r_sq  [4];
    logic                 r_out_valid;
    logic signed [CW-1:0] r_o_sx, r_o_sy, r_o_ex, r_o_ey;
    logic                 r_o_last;

    logic signed [TW-1:0] w_term [4];
    logic [TW-1:0]        w_abs  [4];
    logic [63:0]          w_abs64 [4];
    logic signed [CW-1:0] w_q1 [2], w_q2 [2], w_q3 [2], w_r1 [2], w_r2 [2], w_pm [2];
    logic [63:0]          w_mx, w_my, w_flat;
    logic [64:0]          w_sum;
    logic                 w_leaf;
    logic                 w_slot;
    logic [IDXW-1:0]      w_wi;
    logic [IDXW-1:0]      w_ri;
    logic [LW-1:0]        w_spm1;

    function automatic logic signed [CW-1:0] f_mid(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        return s[CW:1];
    endfunction

    function automatic logic signed [TW-1:0] f_term(input logic signed [CW-1:0] c,
                                                    input logic signed [CW-1:0] n,
                                                    input logic signed [CW-1:0] f);
        logic signed [TW-1:0] ce, ne, fe;
        ce = TW'(c);
        ne = TW'(n);
        fe = TW'(f);
        return (ce <<< 1) + ce - (ne <<< 1) - fe;
    endfunction

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            w_term[a]     = f_term(r_pt[1][a], r_pt[0][a], r_pt[3][a]);
            w_term[a + 2] = f_term(r_pt[2][a], r_pt[3][a], r_pt[0][a]);
            w_q1[a] = f_mid(r_pt[0][a], r_pt[1][a]);
            w_q2[a] = f_mid(r_pt[1][a], r_pt[2][a]);
            w_q3[a] = f_mid(r_pt[2][a], r_pt[3][a]);
            w_r1[a] = f_mid(w_q1[a], w_q2[a]);
            w_r2[a] = f_mid(w_q2[a], w_q3[a]);
            w_pm[a] = f_mid(w_r1[a], w_r2[a]);
        end
        for (int k = 0; k < 4; k++) begin
            w_abs[k]   = w_term[k][TW-1] ? TW'(-w_term[k]) : TW'(w_term[k]);
            w_abs64[k] = 64'(w_abs[k]);
        end
        w_mx   = (r_sq[0] < r_sq[2]) ? r_sq[2] : r_sq[0];
        w_my   = (r_sq[1] < r_sq[3]) ? r_sq[3] : r_sq[1];
        w_sum  = {1'b0, w_mx} + {1'b0, w_my};
        w_flat = w_sum[64] ? '1 : w_sum[63:0];
        w_leaf = (r_level >= LW'(MAX_DEPTH)) || (w_flat < 64'(i_tol));
    end

    assign w_slot = !r_out_valid || o_seg.ready;
    assign w_spm1 = r_sp - LW'(1);
    assign w_wi   = r_sp[IDXW-1:0];
    assign w_ri   = w_spm1[IDXW-1:0];

    assign i_curve.ready      = (r_state == S_IDLE);
    assign o_seg.valid        = r_out_valid;
    assign o_seg.seg_start_x  = r_o_sx;
    assign o_seg.seg_start_y  = r_o_sy;
    assign o_seg.seg_end_x    = r_o_ex;
    assign o_seg.seg_end_y    = r_o_ey;
    assign o_seg.last_segment = r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_seg.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_curve.valid) begin
                        r_pt[0][0] <= i_curve.p0_x;
                        r_pt[0][1] <= i_curve.p0_y;
                        r_pt[1][0] <= i_curve.c1_x;
                        r_pt[1][1] <= i_curve.c1_y;
                        r_pt[2][0] <= i_curve.c2_x;
                        r_pt[2][1] <= i_curve.c2_y;
                        r_pt[3][0] <= i_curve.p3_x;
                        r_pt[3][1] <= i_curve.p3_y;
                        r_sp        <= '0;
                        r_level     <= '0;
                        r_state     <= S_TERMS;
                    end
                end
                S_TERMS: begin
                    for (int k = 0; k < 4; k++) begin
                        r_mag[k] <= w_abs64[k][31:0];
                        r_sat[k] <= (w_abs64[k][63:32] != 32'd0);
                    end
                    r_state <= S_SQUARE;
                end
                S_SQUARE: begin
                    for (int k = 0; k < 4; k++) begin
                        r_sq[k] <= r_sat[k] ? '1 : (64'(r_mag[k]) * 64'(r_mag[k]));
                    end
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (w_leaf) begin
                        r_state <= S_EMIT;
                    end else begin
                        for (int a = 0; a < 2; a++) begin
                            r_stk[w_wi][0][a] <= w_pm[a];
                            r_stk[w_wi][1][a] <= w_r2[a];
                            r_stk[w_wi][2][a] <= w_q3[a];
                            r_stk[w_wi][3][a] <= r_pt[3][a];
                            r_pt[1][a] <= w_q1[a];
                            r_pt[2][a] <= w_r1[a];
                            r_pt[3][a] <= w_pm[a];
                        end
                        r_lvl[w_wi] <= r_level + LW'(1);
                        r_sp        <= r_sp + LW'(1);
                        r_level     <= r_level + LW'(1);
                        r_state     <= S_TERMS;
                    end
                end
                S_EMIT: begin
                    if (w_slot) begin
                        r_out_valid <= 1'b1;
                        r_o_sx      <= r_pt[0][0];
                        r_o_sy      <= r_pt[0][1];
                        r_o_ex      <= r_pt[3][0];
                        r_o_ey      <= r_pt[3][1];
                        r_o_last    <= (r_sp == '0);
                        if (r_sp == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pt    <= r_stk[w_ri];
                            r_level <= r_lvl[w_ri];
                            r_sp    <= w_spm1;
                            r_state <= S_TERMS;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `CBF_ASSERT_ALWAYS(a_sp_bound, i_clk, i_rst_n, r_sp <= LW'(MAX_DEPTH))
    `CBF_ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, r_level <= LW'(MAX_DEPTH))
    `CBF_ASSERT_IMPLY(a_sp_le_level, i_clk, i_rst_n, r_state != S_IDLE, r_sp <= r_level)
    `CBF_ASSERT_IMPLY(a_idle_empty, i_clk, i_rst_n, r_state == S_IDLE, r_sp == '0)
endmodule

### rtl/cubic_bezier_flattener.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cubic_bezier_flattener
// Flattens cubic Bezier curves into line segments by adaptive subdivision.
// ----------------------------------------------------------------------------
// Usage:
//   i_curve takes one item per curve (P0, C1, C2, P3, signed Q16.8) on a
//   valid/ready handshake; a two-entry queue buffers curves ahead of the engine.
//   o_seg delivers the segments of each curve in curve order; last_segment
//   marks the final one. Up to 2^MAX_DEPTH segments per curve.
//   Each tree node passes through the terms, squares and decide states, and each
//   segment through an emit state to issue; a curve of N segments visits 2N-1
//   tree nodes, and the engine takes no new curve from the queue until it has
//   issued its last segment. Each split before the first leaf adds a terms,
//   squares and decide pass ahead of the first segment.
//   The output register holds a segment while the receiver stalls; the engine
//   waits for the slot and the queue keeps accepting up to two curves.
//   The APB port writes flat_tolerance at address 0; it must only be written
//   while no curve is in flight.
//   Reset clears the queue, the engine and sets flat_tolerance to 1.0.
// ----------------------------------------------------------------------------
module cubic_bezier_flattener #(
    parameter int MAX_DEPTH   = cbf_pkg::CBF_MAX_DEPTH,
    parameter int COORD_WIDTH = cbf_pkg::CBF_COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    cbf_curve_if.sink                       i_curve,
    cbf_seg_if.source                       o_seg,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [cbf_pkg::CBF_PADDR_W-1:0] paddr,
    input  logic [cbf_pkg::CBF_PDATA_W-1:0] pwdata,
    output logic [cbf_pkg::CBF_PDATA_W-1:0] prdata,
    output logic                            pready
);
    import cbf_pkg::*;

    logic [CBF_TOL_W-1:0] r_tol;
    logic                 w_sel_tol;

    cbf_curve_if #(.COORD_WIDTH(COORD_WIDTH)) w_q ();

    assign w_sel_tol = (paddr[CBF_PADDR_W-1:CBF_REG_STRIDE_LSB] == CBF_REG_FLAT_TOL);
    assign pready    = 1'b1;
    assign prdata    = w_sel_tol ? CBF_PDATA_W'(r_tol) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= CBF_TOL_RESET;
        end else if (psel && penable && pwrite && w_sel_tol) begin
            r_tol <= pwdata[CBF_TOL_W-1:0];
        end
    end

    cbf_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_curve (i_curve),
        .o_curve (w_q.source)
    );

    cbf_engine #(.MAX_DEPTH(MAX_DEPTH), .COORD_WIDTH(COORD_WIDTH)) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_tol),
        .i_curve (w_q.sink),
        .o_seg   (o_seg)
    );
endmodule
